// ===== hw/rtl/pfs_pkg.sv =====
package pfs_pkg;

    localparam int ARG_BITS_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int CH_W    = 8;
    localparam int ARG_W   = 32;
    localparam int COUNT_W = 16;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    // input commands
    localparam logic [CMD_W-1:0] CMD_FMT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NUM   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd3;

    // parser modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_PCT  = 2'd1;
    localparam logic [1:0] MODE_ARG  = 2'd2;
    localparam logic [1:0] MODE_STR  = 2'd3;

    // conversion kinds
    localparam logic [1:0] KIND_C = 2'd0;
    localparam logic [1:0] KIND_D = 2'd1;
    localparam logic [1:0] KIND_O = 2'd2;
    localparam logic [1:0] KIND_X = 2'd3;

    localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_LC_C    = 8'h63;
    localparam logic [CH_W-1:0] CH_LC_D    = 8'h64;
    localparam logic [CH_W-1:0] CH_LC_O    = 8'h6F;
    localparam logic [CH_W-1:0] CH_LC_S    = 8'h73;
    localparam logic [CH_W-1:0] CH_LC_X    = 8'h78;

    localparam logic [CH_W-1:0] DIGIT_SET [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // microprogram addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] U_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] U_CHR   = 3'd1;
    localparam logic [PC_W-1:0] U_SIGN  = 3'd2;
    localparam logic [PC_W-1:0] U_DAB   = 3'd3;
    localparam logic [PC_W-1:0] U_DLOAD = 3'd4;
    localparam logic [PC_W-1:0] U_SKIP  = 3'd5;
    localparam logic [PC_W-1:0] U_DIGIT = 3'd6;

    // datapath ops
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_DAB   = 3'd1;
    localparam logic [2:0] OP_DLOAD = 3'd2;
    localparam logic [2:0] OP_SKIP  = 3'd3;
    localparam logic [2:0] OP_SHIFT = 3'd4;

    // emit sources
    localparam logic [1:0] EM_NONE  = 2'd0;
    localparam logic [1:0] EM_CHR   = 2'd1;
    localparam logic [1:0] EM_MINUS = 2'd2;
    localparam logic [1:0] EM_DIGIT = 2'd3;

    // repeat conditions: step repeats while true, then goes to target (CD_WAIT goes to the entry)
    localparam logic [2:0] CD_NEVER = 3'd0;
    localparam logic [2:0] CD_WAIT  = 3'd1;
    localparam logic [2:0] CD_CNT   = 3'd2;
    localparam logic [2:0] CD_SKIP  = 3'd3;
    localparam logic [2:0] CD_MORE  = 3'd4;

    typedef struct packed {
        logic [2:0]      op;
        logic [1:0]      emit;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic            go;
        logic [PC_W-1:0] entry;
        logic            stall;
        logic            cnt_more;
        logic            skip_more;
        logic            dig_more;
    } t_stat;

    function automatic t_uword urom(input logic [PC_W-1:0] addr);
        t_uword w;
        case (addr)
            U_IDLE:  w = '{op: OP_NONE,  emit: EM_NONE,  cond: CD_WAIT,  target: U_IDLE};
            U_CHR:   w = '{op: OP_NONE,  emit: EM_CHR,   cond: CD_NEVER, target: U_IDLE};
            U_SIGN:  w = '{op: OP_NONE,  emit: EM_MINUS, cond: CD_NEVER, target: U_DAB};
            U_DAB:   w = '{op: OP_DAB,   emit: EM_NONE,  cond: CD_CNT,   target: U_DLOAD};
            U_DLOAD: w = '{op: OP_DLOAD, emit: EM_NONE,  cond: CD_NEVER, target: U_SKIP};
            U_SKIP:  w = '{op: OP_SKIP,  emit: EM_NONE,  cond: CD_SKIP,  target: U_DIGIT};
            U_DIGIT: w = '{op: OP_SHIFT, emit: EM_DIGIT, cond: CD_MORE,  target: U_IDLE};
            default: w = '{op: OP_NONE,  emit: EM_NONE,  cond: CD_NEVER, target: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/pfs_if.sv =====
interface pfs_in_if;
    logic                        valid;
    logic                        ready;
    logic [pfs_pkg::CMD_W-1:0]   cmd;
    logic [pfs_pkg::CH_W-1:0]    ch;
    logic [pfs_pkg::ARG_W-1:0]   arg;

    modport source (output valid, cmd, ch, arg, input ready);
    modport sink   (input valid, cmd, ch, arg, output ready);
endinterface

interface pfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [pfs_pkg::CH_W-1:0]    out_char;
    logic                        last;
    logic [pfs_pkg::COUNT_W-1:0] count;

    modport source (output valid, out_char, last, count, input ready);
    modport sink   (input valid, out_char, last, count, output ready);
endinterface

interface pfs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pfs_pkg::COUNT_W-1:0] out_limit;

    modport source (output valid, out_limit, input ready);
    modport sink   (input valid, out_limit, output ready);
endinterface

// ===== hw/rtl/printf_format_stream_top.sv =====
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   cmd[1:0], ch[7:0], arg[31:0]
// o_out     out  valid/ready   out_char[7:0], last, count[15:0]
// i_cfg     in   valid/ready   out_limit[15:0]
//
// One item at a time: the input is ready only while the microprogram is idle.
// %o / %x argument: digit positions (11 octal, 8 hex) for 32 bits, leading zeros skipped.
// %d argument: ARG_BITS steps of bit-serial BCD, then 10 digit positions for 32 bits.
// Output stalls hold the microprogram at its emit step; one output register.
// Synchronous active-low reset; out_limit resets to 65535.
module printf_format_stream_top #(
    parameter int ARG_BITS = pfs_pkg::ARG_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfs_in_if.sink    i_in,
    pfs_out_if.source o_out,
    pfs_cfg_if.sink   i_cfg
);

    pfs_pkg::t_uword w_ctrl;
    pfs_pkg::t_stat  w_stat;

    pfs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    pfs_dpath #(
        .ARG_BITS (ARG_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

endmodule

// ===== hw/rtl/pfs_useq.sv =====
module pfs_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfs_pkg::t_stat  i_stat,
    output pfs_pkg::t_uword o_ctrl
);

    logic [pfs_pkg::PC_W-1:0] r_pc;
    logic [pfs_pkg::PC_W-1:0] n_pc;
    pfs_pkg::t_uword          w_word;

    assign w_word = pfs_pkg::urom(r_pc);
    assign o_ctrl = w_word;

    always_comb begin
        n_pc = w_word.target;
        if (i_stat.stall) begin
            n_pc = r_pc;
        end else begin
            case (w_word.cond)
                pfs_pkg::CD_WAIT: begin
                    n_pc = i_stat.go ? i_stat.entry : r_pc;
                end
                pfs_pkg::CD_CNT: begin
                    if (i_stat.cnt_more) n_pc = r_pc;
                end
                pfs_pkg::CD_SKIP: begin
                    if (i_stat.skip_more) n_pc = r_pc;
                end
                pfs_pkg::CD_MORE: begin
                    if (i_stat.dig_more) n_pc = r_pc;
                end
                default: begin
                    n_pc = w_word.target;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pfs_pkg::U_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hw/rtl/pfs_dpath.sv =====
module pfs_dpath #(
    parameter int ARG_BITS = pfs_pkg::ARG_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pfs_in_if.sink          i_in,
    pfs_out_if.source       o_out,
    pfs_cfg_if.sink         i_cfg,
    input  pfs_pkg::t_uword i_ctrl,
    output pfs_pkg::t_stat  o_stat
);

    localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
    localparam int OCT_DIGITS = (ARG_BITS + 2) / 3;
    localparam int DEC_DIGITS = (ARG_BITS * 3) / 10 + 1;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int OCT_W      = OCT_DIGITS * 3;
    localparam int DEC_W      = DEC_DIGITS * 4;
    localparam int WORK_A     = (HEX_W > OCT_W) ? HEX_W : OCT_W;
    localparam int WORK_W     = (WORK_A > DEC_W) ? WORK_A : DEC_W;
    localparam int MAX_DIGITS = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
    localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);
    localparam int BCNT_W     = $clog2(ARG_BITS + 1);

    // control state
    logic [15:0]                   r_limit;
    logic [1:0]                    r_mode;
    logic [1:0]                    r_kind;
    logic [pfs_pkg::COUNT_W-1:0]   r_count;
    logic                          r_out_valid;

    // payload
    logic [pfs_pkg::CH_W-1:0]      r_ch;
    logic                          r_neg;
    logic                          r_oct;
    logic [ARG_BITS-1:0]           r_val;
    logic [DEC_W-1:0]              r_bcd;
    logic [BCNT_W-1:0]             r_cnt;
    logic [WORK_W-1:0]             r_work;
    logic [LEFT_W-1:0]             r_left;
    logic [pfs_pkg::CH_W-1:0]      r_out_char;
    logic                          r_out_last;
    logic [pfs_pkg::COUNT_W-1:0]   r_out_count;

    logic                          w_in_acc;
    logic [ARG_BITS-1:0]           w_v;
    logic [ARG_BITS-1:0]           w_mag;
    logic [1:0]                    n_mode;
    logic [1:0]                    n_kind;
    logic [pfs_pkg::PC_W-1:0]      w_entry;
    logic [pfs_pkg::CH_W-1:0]      w_ch_load;
    logic [DEC_W-1:0]              w_adj;
    logic [3:0]                    w_top;
    logic [WORK_W-1:0]             w_shifted;
    logic                          w_skip_more;
    logic                          w_req;
    logic                          w_fin;
    logic [pfs_pkg::CH_W-1:0]      w_char;
    logic                          w_room;
    logic                          w_slot;
    logic                          w_stall;
    logic                          w_fire;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (i_ctrl.cond == pfs_pkg::CD_WAIT);
    assign i_cfg.ready = 1'b1;

    assign w_v   = ARG_BITS'({{ARG_BITS{1'b0}}, i_in.arg});
    assign w_mag = w_v[ARG_BITS-1] ? (~w_v + 1'b1) : w_v;

    // parser: next mode and program entry for the incoming item
    always_comb begin
        n_mode    = r_mode;
        n_kind    = r_kind;
        w_entry   = pfs_pkg::U_IDLE;
        w_ch_load = i_in.ch;
        case (i_in.cmd)
            pfs_pkg::CMD_FMT: begin
                if (r_mode == pfs_pkg::MODE_TEXT) begin
                    if (i_in.ch == pfs_pkg::CH_PERCENT) begin
                        n_mode = pfs_pkg::MODE_PCT;
                    end else if (i_in.ch != pfs_pkg::CH_NUL) begin
                        w_entry = pfs_pkg::U_CHR;
                    end
                end else if (r_mode == pfs_pkg::MODE_PCT) begin
                    n_mode = pfs_pkg::MODE_TEXT;
                    if (i_in.ch == pfs_pkg::CH_LC_C) begin
                        n_kind = pfs_pkg::KIND_C;
                        n_mode = pfs_pkg::MODE_ARG;
                    end else if (i_in.ch == pfs_pkg::CH_LC_D) begin
                        n_kind = pfs_pkg::KIND_D;
                        n_mode = pfs_pkg::MODE_ARG;
                    end else if (i_in.ch == pfs_pkg::CH_LC_O) begin
                        n_kind = pfs_pkg::KIND_O;
                        n_mode = pfs_pkg::MODE_ARG;
                    end else if (i_in.ch == pfs_pkg::CH_LC_X) begin
                        n_kind = pfs_pkg::KIND_X;
                        n_mode = pfs_pkg::MODE_ARG;
                    end else if (i_in.ch == pfs_pkg::CH_LC_S) begin
                        n_mode = pfs_pkg::MODE_STR;
                    end
                end
            end
            pfs_pkg::CMD_NUM: begin
                if (r_mode == pfs_pkg::MODE_ARG) begin
                    n_mode    = pfs_pkg::MODE_TEXT;
                    w_ch_load = w_v[7:0];
                    case (r_kind)
                        pfs_pkg::KIND_C: w_entry = pfs_pkg::U_CHR;
                        pfs_pkg::KIND_D: w_entry = pfs_pkg::U_SIGN;
                        default:         w_entry = pfs_pkg::U_SKIP;
                    endcase
                end
            end
            pfs_pkg::CMD_STR: begin
                if (r_mode == pfs_pkg::MODE_STR) begin
                    if (i_in.ch == pfs_pkg::CH_NUL) begin
                        n_mode = pfs_pkg::MODE_TEXT;
                    end else begin
                        w_entry = pfs_pkg::U_CHR;
                    end
                end
            end
            default: begin
                n_mode = pfs_pkg::MODE_TEXT;
                n_kind = pfs_pkg::KIND_C;
            end
        endcase
    end

    // shift-add-3 correction on every BCD digit
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            w_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? (r_bcd[i*4 +: 4] + 4'd3)
                                                        : r_bcd[i*4 +: 4];
        end
    end

    assign w_top       = r_oct ? {1'b0, r_work[WORK_W-1 -: 3]} : r_work[WORK_W-1 -: 4];
    assign w_shifted   = r_oct ? (r_work << 3) : (r_work << 4);
    assign w_skip_more = (w_top == 4'd0) && (r_left > LEFT_W'(1));

    always_comb begin
        w_req  = 1'b0;
        w_fin  = 1'b0;
        w_char = r_ch;
        case (i_ctrl.emit)
            pfs_pkg::EM_CHR: begin
                w_req = 1'b1;
                w_fin = 1'b1;
            end
            pfs_pkg::EM_MINUS: begin
                w_req  = r_neg;
                w_char = pfs_pkg::CH_MINUS;
            end
            pfs_pkg::EM_DIGIT: begin
                w_req  = 1'b1;
                w_fin  = (r_left == LEFT_W'(1));
                w_char = pfs_pkg::DIGIT_SET[w_top];
            end
            default: begin
                w_req = 1'b0;
            end
        endcase
    end

    // past the limit a character is dropped and the program moves on
    assign w_room  = (r_count < r_limit);
    assign w_slot  = !r_out_valid || o_out.ready;
    assign w_stall = w_req && w_room && !w_slot;
    assign w_fire  = w_req && w_room && w_slot;

    assign o_stat.go        = w_in_acc;
    assign o_stat.entry     = w_entry;
    assign o_stat.stall     = w_stall;
    assign o_stat.cnt_more  = (r_cnt != BCNT_W'(1));
    assign o_stat.skip_more = w_skip_more;
    assign o_stat.dig_more  = (r_left > LEFT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= pfs_pkg::LIMIT_RESET;
            r_mode      <= pfs_pkg::MODE_TEXT;
            r_kind      <= pfs_pkg::KIND_C;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_limit <= i_cfg.out_limit;
            if (w_in_acc) begin
                r_mode <= n_mode;
                r_kind <= n_kind;
                if (i_in.cmd == pfs_pkg::CMD_BEGIN) r_count <= '0;
            end else if (w_fire) begin
                r_count <= r_count + 16'd1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch   <= w_ch_load;
            r_neg  <= w_v[ARG_BITS-1];
            r_val  <= w_mag;
            r_bcd  <= '0;
            r_cnt  <= BCNT_W'(ARG_BITS);
            r_oct  <= (r_kind == pfs_pkg::KIND_O);
            if (r_kind == pfs_pkg::KIND_O) begin
                r_work <= WORK_W'(w_v) << (WORK_W - OCT_W);
                r_left <= LEFT_W'(OCT_DIGITS);
            end else begin
                r_work <= WORK_W'(w_v) << (WORK_W - HEX_W);
                r_left <= LEFT_W'(HEX_DIGITS);
            end
        end else if (!w_stall) begin
            case (i_ctrl.op)
                pfs_pkg::OP_DAB: begin
                    r_bcd <= {w_adj[DEC_W-2:0], r_val[ARG_BITS-1]};
                    r_val <= r_val << 1;
                    r_cnt <= r_cnt - 1'b1;
                end
                pfs_pkg::OP_DLOAD: begin
                    r_work <= WORK_W'(r_bcd) << (WORK_W - DEC_W);
                    r_left <= LEFT_W'(DEC_DIGITS);
                    r_oct  <= 1'b0;
                end
                pfs_pkg::OP_SKIP: begin
                    if (w_skip_more) begin
                        r_work <= w_shifted;
                        r_left <= r_left - 1'b1;
                    end
                end
                pfs_pkg::OP_SHIFT: begin
                    r_work <= w_shifted;
                    r_left <= r_left - 1'b1;
                end
                default: begin
                    r_left <= r_left;
                end
            endcase
        end
        if (w_fire) begin
            r_out_char  <= w_char;
            r_out_last  <= w_fin || ((r_count + 16'd1) == r_limit);
            r_out_count <= r_count + 16'd1;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.last     = r_out_last;
    assign o_out.count    = r_out_count;

`ifndef SYNTHESIS
    a_dab_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == pfs_pkg::OP_DAB) |-> (r_cnt != '0))
        else $error("double-dabble step with empty bit counter");

    a_digit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit == pfs_pkg::EM_DIGIT) |-> (r_left != '0))
        else $error("digit emitted with no digits left");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_count == $past(r_count) + 16'd1))
        else $error("count did not advance on emitted character");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> (i_ctrl == $past(i_ctrl)))
        else $error("sequencer moved during output stall");
`endif

endmodule
